[src/srr_pkg.sv]
// shared types and constants for the selective-repeat receiver
package srr_pkg;

  localparam int WINDOW_SLOTS = 8;
  localparam int SLOT_W       = $clog2(WINDOW_SLOTS);

  localparam logic [32:0] EXP_MIN = {1'b1, 32'd0};

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_ERR_ACK = 2'd2,
    KIND_ABORT   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FETCH,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic        abort;
    logic [7:0]  slot;
    logic [39:0] cumulative_bytes;
    logic [31:0] packets_remaining;
    logic [15:0] payload_length;
    logic [31:0] payload_tag;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  ack_slot;
    logic [39:0] ack_bytes;
    logic [39:0] bytes_written;
    logic [31:0] out_tag;
    logic [15:0] out_length;
    logic        transfer_done;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [39:0] bytes;
    logic [15:0] length;
    logic [31:0] tag;
  } slot_entry_t;

  function automatic logic done_of(input logic [32:0] expected);
    done_of = expected[32] || (expected == 33'd0);
  endfunction

  function automatic logic [32:0] dec_sat(input logic [32:0] expected);
    dec_sat = (expected == EXP_MIN) ? expected : expected - 33'd1;
  endfunction

endpackage

[src/srr_ram.sv]
// generic single-port-write ram with registered read
module srr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/selective_repeat_receiver.sv]
// selective-repeat receiver top level: window control and slot store
//
//   channel | signals                      | direction | transfer
//   in      | in_valid, in_ready, in_data  | input     | one arriving packet
//   out     | out_valid, out_ready, out_data | output  | one delivery or ack
//
// abort, bad slot and stale packets pass only the accept and check steps
// new packet: accept, check, fetch, drain of n in-order slots (one ram read each)
// the next packet is taken once the last result has been registered
// reset clears the slot flags and counters; no clearing pass
// a stalled output holds the engine in place with the ram read address held
module selective_repeat_receiver (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  srr_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output srr_pkg::out_item_t out_data
);

  import srr_pkg::*;

  state_t            state, state_next;
  in_item_t          in_q;
  logic [WINDOW_SLOTS-1:0] full, full_next;
  logic [WINDOW_SLOTS-1:0] bytes_valid, bytes_valid_next;
  logic [SLOT_W-1:0] next_slot, next_slot_next;
  logic [39:0]       delivered, delivered_next;
  logic [32:0]       expected, expected_next;
  logic              seen_first, seen_first_next;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_raddr;
  slot_entry_t       ram_wdata;
  slot_entry_t       ram_rdata;

  logic              emit;
  out_item_t         res;
  logic              out_free;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] slot_inc;
  logic [39:0]       stored_bytes;
  logic [32:0]       exp_load;
  logic [32:0]       exp_dec;
  logic              bad_slot;
  logic              stale;

  srr_ram #(
    .WIDTH($bits(slot_entry_t)),
    .DEPTH(WINDOW_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_free     = !out_valid || out_ready;
  assign idx          = in_q.slot[SLOT_W-1:0];
  assign slot_inc     = (next_slot == SLOT_W'(WINDOW_SLOTS - 1)) ? '0 : next_slot + 1'b1;
  assign bad_slot     = in_q.slot >= 8'(WINDOW_SLOTS);
  assign stored_bytes = bytes_valid[idx] ? ram_rdata.bytes : 40'd0;
  assign exp_load     = seen_first ? expected : {1'b0, in_q.packets_remaining};
  assign exp_dec      = dec_sat(expected);
  assign stale        = full[idx] || (delivered < stored_bytes) ||
                        (in_q.cumulative_bytes <= delivered);

  assign ram_wdata.bytes  = in_q.cumulative_bytes;
  assign ram_wdata.length = in_q.payload_length;
  assign ram_wdata.tag    = in_q.payload_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      full        <= '0;
      bytes_valid <= '0;
      next_slot   <= '0;
      delivered   <= '0;
      expected    <= '0;
      seen_first  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      full        <= full_next;
      bytes_valid <= bytes_valid_next;
      next_slot   <= next_slot_next;
      delivered   <= delivered_next;
      expected    <= expected_next;
      seen_first  <= seen_first_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
    if (emit) begin
      out_data <= res;
    end
  end

  always_comb begin
    state_next       = state;
    full_next        = full;
    bytes_valid_next = bytes_valid;
    next_slot_next   = next_slot;
    delivered_next   = delivered;
    expected_next    = expected;
    seen_first_next  = seen_first;
    ram_we           = 1'b0;
    ram_raddr        = next_slot;
    in_ready         = 1'b0;
    emit             = 1'b0;
    res              = '0;
    res.kind         = KIND_ACK;

    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = in_data.slot[SLOT_W-1:0];
        if (in_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        ram_raddr = idx;
        if (out_free) begin
          if (in_q.abort) begin
            emit              = 1'b1;
            res.kind          = KIND_ABORT;
            res.transfer_done = done_of(expected);
            res.last          = 1'b1;
            state_next        = ST_IDLE;
          end else if (bad_slot) begin
            emit              = 1'b1;
            res.kind          = KIND_ERR_ACK;
            res.ack_slot      = in_q.slot;
            res.transfer_done = done_of(expected);
            res.last          = 1'b1;
            state_next        = ST_IDLE;
          end else begin
            seen_first_next = 1'b1;
            expected_next   = exp_load;
            if (stale) begin
              emit              = 1'b1;
              res.ack_slot      = in_q.slot;
              res.ack_bytes     = in_q.cumulative_bytes;
              res.transfer_done = done_of(exp_load);
              res.last          = 1'b1;
              state_next        = ST_IDLE;
            end else begin
              ram_we                = 1'b1;
              full_next[idx]        = 1'b1;
              bytes_valid_next[idx] = 1'b1;
              state_next            = ST_FETCH;
            end
          end
        end
      end
      ST_FETCH: begin
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_free) begin
          emit = 1'b1;
          if (full[next_slot]) begin
            delivered_next       = ram_rdata.bytes;
            expected_next        = exp_dec;
            full_next[next_slot] = 1'b0;
            next_slot_next       = slot_inc;
            ram_raddr            = slot_inc;
            res.kind             = KIND_DELIVER;
            res.out_tag          = ram_rdata.tag;
            res.out_length       = ram_rdata.length;
            res.transfer_done    = done_of(exp_dec);
          end else begin
            res.ack_slot      = in_q.slot;
            res.ack_bytes     = in_q.cumulative_bytes;
            res.transfer_done = done_of(expected);
            res.last          = 1'b1;
            state_next        = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res.bytes_written = delivered_next;
  end

endmodule

[dv/tb_top.sv]
// testbench for selective_repeat_receiver: window predictor, directed table, random rounds
`timescale 1ns / 100ps

module tb_top;
  import srr_pkg::*;

  localparam int DIR_ROWS    = 22;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  selective_repeat_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receive window as the block should hold it
  logic               win_full  [WINDOW_SLOTS];
  logic [39:0]        win_bytes [WINDOW_SLOTS];
  logic [31:0]        win_tag   [WINDOW_SLOTS];
  logic [15:0]        win_len   [WINDOW_SLOTS];
  int                 win_head;
  logic [39:0]        written_bytes;
  logic signed [32:0] pkts_left;
  logic               first_seen;

  out_item_t due_results[$];

  // sender side of the random rounds
  logic        snd_pending [WINDOW_SLOTS];
  logic [39:0] snd_cum     [WINDOW_SLOTS];
  logic [15:0] snd_len     [WINDOW_SLOTS];
  logic [31:0] snd_tag     [WINDOW_SLOTS];
  logic [39:0] snd_top;

  int send_idle = 0;
  int recv_idle = 0;
  int sent      = 0;
  int faults    = 0;
  int cycles    = 0;
  int hold_cnt  = 0;
  bit hold_go   = 1'b0;
  bit hold_used = 1'b0;

  in_item_t  dir_pkt   [DIR_ROWS];
  bit        dir_typed [DIR_ROWS];
  out_item_t dir_want  [DIR_ROWS];
  out_item_t want;

  function automatic out_item_t result_of(kind_t k, logic [7:0] aslot, logic [39:0] abytes,
                                          logic [31:0] tag, logic [15:0] len, logic lst);
    out_item_t r;
    r.kind          = k;
    r.ack_slot      = aslot;
    r.ack_bytes     = abytes;
    r.bytes_written = written_bytes;
    r.out_tag       = tag;
    r.out_length    = len;
    r.transfer_done = (pkts_left <= 0);
    r.last          = lst;
    return r;
  endfunction

  // returns the number of in-order deliveries the packet releases
  function automatic int take_packet(in_item_t p, bit record);
    int s;
    int drained;
    drained = 0;
    s = p.slot;
    if (p.abort) begin
      if (record) due_results.push_back(result_of(KIND_ABORT, 8'd0, 40'd0, 32'd0, 16'd0, 1'b1));
      return 0;
    end
    if (s >= WINDOW_SLOTS) begin
      if (record) due_results.push_back(result_of(KIND_ERR_ACK, p.slot, 40'd0, 32'd0, 16'd0, 1'b1));
      return 0;
    end
    if (!first_seen) begin
      pkts_left  = {1'b0, p.packets_remaining};
      first_seen = 1'b1;
    end
    if (win_full[s] || written_bytes < win_bytes[s] || p.cumulative_bytes <= written_bytes) begin
      if (record)
        due_results.push_back(result_of(KIND_ACK, p.slot, p.cumulative_bytes, 32'd0, 16'd0, 1'b1));
      return 0;
    end
    win_full[s]  = 1'b1;
    win_bytes[s] = p.cumulative_bytes;
    win_tag[s]   = p.payload_tag;
    win_len[s]   = p.payload_length;
    while (drained < WINDOW_SLOTS && win_full[win_head]) begin
      drained++;
      written_bytes = win_bytes[win_head];
      if (pkts_left != $signed(EXP_MIN)) pkts_left = pkts_left - 1;
      win_full[win_head] = 1'b0;
      if (record)
        due_results.push_back(result_of(KIND_DELIVER, 8'd0, 40'd0, win_tag[win_head],
                                        win_len[win_head], 1'b0));
      win_head = (win_head + 1) % WINDOW_SLOTS;
    end
    if (record)
      due_results.push_back(result_of(KIND_ACK, p.slot, p.cumulative_bytes, 32'd0, 16'd0, 1'b1));
    return drained;
  endfunction

  function automatic in_item_t noise_packet();
    in_item_t    p;
    int          pick;
    logic [63:0] wide;
    pick = $urandom_range(2);
    wide = {$urandom, $urandom};
    p.abort = (pick == 0);
    if (pick == 1) p.slot = 8'($urandom_range(255, WINDOW_SLOTS));
    else if (pick == 2) p.slot = 8'($urandom_range(WINDOW_SLOTS - 1, 0));
    else p.slot = 8'($urandom);
    // stale packets never store, so the window keeps moving
    if (pick == 2) p.cumulative_bytes = 40'(wide % (64'(written_bytes) + 64'd1));
    else p.cumulative_bytes = wide[39:0];
    p.packets_remaining = $urandom;
    p.payload_length    = 16'($urandom);
    p.payload_tag       = $urandom;
    return p;
  endfunction

  task automatic offer_packet(in_item_t p, bit record);
    int head0;
    int drained;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    head0   = win_head;
    drained = take_packet(p, record);
    for (int k = 0; k < drained; k++) snd_pending[(head0 + k) % WINDOW_SLOTS] = 1'b0;
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic run_rounds(int quota);
    int       stop_at;
    int       order [WINDOW_SLOTS];
    int       s;
    int       j;
    int       t;
    in_item_t p;
    stop_at = sent + quota;
    while (sent < stop_at) begin
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
        s = (win_head + i) % WINDOW_SLOTS;
        if (!snd_pending[s]) begin
          snd_top        = snd_top + 40'($urandom_range(70000, 1));
          snd_cum[s]     = snd_top;
          snd_len[s]     = 16'($urandom);
          snd_tag[s]     = $urandom;
          snd_pending[s] = 1'b1;
        end
        order[i] = s;
      end
      for (int i = WINDOW_SLOTS - 1; i > 0; i--) begin
        j        = $urandom_range(i);
        t        = order[i];
        order[i] = order[j];
        order[j] = t;
      end
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
        if ($urandom_range(99) < 15) offer_packet(noise_packet(), 1'b1);
        s = order[i];
        // some packets go missing and are resent next round
        if (snd_pending[s] && $urandom_range(99) < 85) begin
          p.abort             = 1'b0;
          p.slot              = 8'(s);
          p.cumulative_bytes  = snd_cum[s];
          p.packets_remaining = $urandom;
          p.payload_length    = snd_len[s];
          p.payload_tag       = snd_tag[s];
          offer_packet(p, 1'b1);
          if ($urandom_range(99) < 10) offer_packet(p, 1'b1);
        end
      end
    end
  endtask

  function automatic bit field_ok(string name, logic [39:0] w, logic [39:0] g);
    if (w !== g) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, w, g);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        faults++;
        $display("%0t: transfer with nothing expected, expected none, got %p", $time, out_data);
      end else begin
        want = due_results.pop_front();
        if (!(field_ok("kind", want.kind, out_data.kind) &
              field_ok("ack_slot", want.ack_slot, out_data.ack_slot) &
              field_ok("ack_bytes", want.ack_bytes, out_data.ack_bytes) &
              field_ok("bytes_written", want.bytes_written, out_data.bytes_written) &
              field_ok("out_tag", want.out_tag, out_data.out_tag) &
              field_ok("out_length", want.out_length, out_data.out_length) &
              field_ok("transfer_done", want.transfer_done, out_data.transfer_done) &
              field_ok("last", want.last, out_data.last)))
          faults++;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_cnt  <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      win_full[i]    = 1'b0;
      win_bytes[i]   = '0;
      snd_pending[i] = 1'b0;
    end
    win_head      = 0;
    written_bytes = '0;
    pkts_left     = '0;
    first_seen    = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      dir_typed[i] = 1'b0;
      dir_want[i]  = '0;
    end
    // done reads high before the first packet
    dir_pkt[0]  = '{1'b1, 8'hff, 40'hff_ffff_ffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff};
    dir_want[0] = '{KIND_ABORT, 8'd0, 40'd0, 40'd0, 32'd0, 16'd0, 1'b1, 1'b1};
    dir_pkt[1]  = '{1'b0, 8'(WINDOW_SLOTS), 40'd0, 32'd0, 16'd0, 32'd0};
    dir_want[1] = '{KIND_ERR_ACK, 8'(WINDOW_SLOTS), 40'd0, 40'd0, 32'd0, 16'd0, 1'b1, 1'b1};
    dir_pkt[2]  = '{1'b0, 8'hff, 40'hff_ffff_ffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff};
    dir_want[2] = '{KIND_ERR_ACK, 8'hff, 40'd0, 40'd0, 32'd0, 16'd0, 1'b1, 1'b1};
    // first packet is stale but still loads the count
    dir_pkt[3]  = '{1'b0, 8'd0, 40'd0, 32'd3, 16'd10, 32'h5};
    dir_want[3] = '{KIND_ACK, 8'd0, 40'd0, 40'd0, 32'd0, 16'd0, 1'b0, 1'b1};
    for (int i = 0; i < 4; i++) dir_typed[i] = 1'b1;
    dir_pkt[4]  = '{1'b0, 8'd1, 40'd2000, 32'd0, 16'd1000, 32'h1};
    dir_pkt[5]  = '{1'b0, 8'd1, 40'd2000, 32'd0, 16'd1000, 32'h1};
    dir_pkt[6]  = '{1'b0, 8'd0, 40'd1000, 32'd0, 16'd1000, 32'h2};
    dir_pkt[7]  = '{1'b0, 8'd2, 40'd1000, 32'd0, 16'd7, 32'h3};
    dir_pkt[8]  = '{1'b0, 8'd2, 40'd3000, 32'd0, 16'hffff, 32'hffff_ffff};
    dir_pkt[9]  = '{1'b1, 8'd0, 40'd0, 32'd0, 16'd0, 32'd0};
    // fill the rest of the window out of order, then the head drains all of it
    dir_pkt[10] = '{1'b0, 8'd4, 40'd5000, 32'd0, 16'd0, 32'd0};
    dir_pkt[11] = '{1'b0, 8'd5, 40'd6000, 32'd0, 16'd55, 32'h55};
    dir_pkt[12] = '{1'b0, 8'd6, 40'd7000, 32'd0, 16'd66, 32'h66};
    dir_pkt[13] = '{1'b0, 8'd7, 40'd8000, 32'd0, 16'd77, 32'h77};
    dir_pkt[14] = '{1'b0, 8'd0, 40'd9000, 32'd0, 16'd88, 32'h88};
    dir_pkt[15] = '{1'b0, 8'd1, 40'd10000, 32'd0, 16'd99, 32'h99};
    dir_pkt[16] = '{1'b0, 8'd2, 40'd11000, 32'd0, 16'd11, 32'haa};
    dir_pkt[17] = '{1'b0, 8'd3, 40'd4000, 32'd0, 16'd33, 32'hbb};
    dir_pkt[18] = '{1'b0, 8'd4, 40'd13000, 32'd0, 16'd44, 32'hcc};
    dir_pkt[19] = '{1'b0, 8'd4, 40'hff_ffff_ffff, 32'd0, 16'd44, 32'hcc};
    dir_pkt[20] = '{1'b0, 8'd3, 40'd12000, 32'd0, 16'd33, 32'hdd};
    dir_pkt[21] = '{1'b0, 8'd9, 40'd12000, 32'd0, 16'd0, 32'd0};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle = 36;
    recv_idle = 48;
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_typed[i]) due_results.push_back(dir_want[i]);
      offer_packet(dir_pkt[i], !dir_typed[i]);
    end

    snd_top = written_bytes;
    run_rounds(100);
    send_idle = 48;
    recv_idle = 36;
    run_rounds(100);
    send_idle = 0;
    recv_idle = 0;
    hold_go   = 1'b1;
    run_rounds(100);

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (faults == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
